// ===== sv/psf_pkg.sv =====
// shared types and constants of the peephole superinstruction fuser
package psf_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int MAX_PUSH    = 3;

   // configuration register indexes
   localparam logic [2:0] REG_NOP        = 3'd0;
   localparam logic [2:0] REG_PUT_CONST  = 3'd1;
   localparam logic [2:0] REG_LOAD_LOCAL = 3'd2;
   localparam logic [2:0] REG_MUL        = 3'd3;
   localparam logic [2:0] REG_DIV        = 3'd4;
   localparam logic [2:0] REG_ADD        = 3'd5;
   localparam logic [2:0] REG_SUB        = 3'd6;
   localparam logic [2:0] REG_FUSED_BASE = 3'd7;

   typedef struct packed {
      logic [7:0]  opcode;
      logic [15:0] flag_operand;
      logic [15:0] wide_operand;
      logic        last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_opcode;
      logic [15:0] out_flag;
      logic [15:0] out_wide;
      logic        out_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] nop_code;
      logic [7:0] put_const_code;
      logic [7:0] load_local_code;
      logic [7:0] mul_code;
      logic [7:0] div_code;
      logic [7:0] add_code;
      logic [7:0] sub_code;
      logic [7:0] fused_base_code;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      nop_code:        8'd0,
      put_const_code:  8'd1,
      load_local_code: 8'd2,
      mul_code:        8'd3,
      div_code:        8'd4,
      add_code:        8'd5,
      sub_code:        8'd6,
      fused_base_code: 8'd7
   };

   // results produced by one accepted transaction
   typedef struct packed {
      logic [1:0]                      count;
      rsp_payload_type [MAX_PUSH-1:0]  item;
   } push_type;

endpackage

// ===== sv/peephole_superinstruction_fuser.sv =====
// top level of the peephole superinstruction fuser
// results caused by a transaction are written into the registered result queue when it is accepted
// throughput: one instruction per cycle while the input is not stalled; a closing instruction emits up to three
//   results, one per cycle while the output is not stalled, and the input stalls while more than one result is queued
// reset: synchronous, active high; window empty, matcher at start, queue empty,
//   registers back to their default opcodes
module peephole_superinstruction_fuser (
   input  logic                     clock,
   input  logic                     reset,
   // instruction input
   input  logic                     req_valid,
   output logic                     req_stall,
   input  psf_pkg::req_payload_type req_payload,
   // rewritten instruction output
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output psf_pkg::rsp_payload_type rsp_payload,
   // opcode registers
   input  logic                     csr_wr_en,
   input  logic [2:0]               csr_index,
   input  logic [7:0]               csr_wr_data
);

   psf_pkg::cfg_type  cfg_ff, cfg_in;
   psf_pkg::push_type push;
   logic              req_accept;
   logic              rsp_pop;
   logic              room;
   logic [psf_pkg::QUEUE_AW:0] q_count;

   // a transaction is taken only when the queue can hold its whole burst
   assign req_stall  = !room;
   assign req_accept = req_valid && !req_stall;
   assign rsp_pop    = rsp_valid && !rsp_stall;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            psf_pkg::REG_NOP:        cfg_in.nop_code        = csr_wr_data;
            psf_pkg::REG_PUT_CONST:  cfg_in.put_const_code  = csr_wr_data;
            psf_pkg::REG_LOAD_LOCAL: cfg_in.load_local_code = csr_wr_data;
            psf_pkg::REG_MUL:        cfg_in.mul_code        = csr_wr_data;
            psf_pkg::REG_DIV:        cfg_in.div_code        = csr_wr_data;
            psf_pkg::REG_ADD:        cfg_in.add_code        = csr_wr_data;
            psf_pkg::REG_SUB:        cfg_in.sub_code        = csr_wr_data;
            psf_pkg::REG_FUSED_BASE: cfg_in.fused_base_code = csr_wr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= psf_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // matcher and two-entry window, results pushed on the accept edge
   psf_matcher u_matcher (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_payload),
      .cfg    (cfg_ff),
      .push   (push)
   );

   // result queue decouples the burst from the downstream stall
   psf_out_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (rsp_pop),
      .room   (room),
      .valid  (rsp_valid),
      .data   (rsp_payload),
      .count  (q_count)
   );

`ifndef SYNTHESIS
   // the queue never holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      q_count <= (psf_pkg::QUEUE_AW+1)'(psf_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   // a closing instruction always leaves a result waiting
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.last |=> rsp_valid)
      else $error("closing instruction produced no result");

   // nothing is pushed unless a transaction was accepted
   assert property (@(posedge clock) disable iff (reset)
      !req_accept |-> push.count == 2'd0)
      else $error("result pushed without a transaction");
`endif

endmodule

// ===== sv/psf_matcher.sv =====
// window, matcher state machine and rewrite logic
module psf_matcher (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  psf_pkg::req_payload_type req,
   input  psf_pkg::cfg_type         cfg,
   output psf_pkg::push_type        push
);

   localparam logic [2:0] ST_START = 3'd0;
   localparam logic [2:0] ST_K     = 3'd1;
   localparam logic [2:0] ST_L     = 3'd2;
   localparam logic [2:0] ST_KL    = 3'd3;
   localparam logic [2:0] ST_KK    = 3'd4;
   localparam logic [2:0] ST_LL    = 3'd5;

   localparam logic [1:0] PAIR_KL = 2'd0;
   localparam logic [1:0] PAIR_KK = 2'd1;
   localparam logic [1:0] PAIR_LL = 2'd2;

   psf_pkg::rsp_payload_type win_ff [2];
   psf_pkg::rsp_payload_type win_in [2];
   logic [1:0] fill_ff, fill_in;
   logic [2:0] state_ff, state_in;

   always_comb begin
      logic [2:0]  next;
      logic        arith_hit;
      logic [1:0]  arith;
      logic [1:0]  pair;
      logic [7:0]  lead_code;
      logic [7:0]  trail_code;
      logic [7:0]  fused_op;
      psf_pkg::rsp_payload_type cur;
      psf_pkg::rsp_payload_type nop_item;

      next      = ST_START;
      arith_hit = 1'b0;
      arith     = 2'd0;
      pair      = PAIR_KL;
      cur       = '{out_opcode: req.opcode, out_flag: req.flag_operand,
                    out_wide: req.wide_operand, out_last: 1'b1};
      nop_item  = '{out_opcode: cfg.nop_code, out_flag: 16'd0,
                    out_wide: 16'd0, out_last: 1'b0};

      unique case (state_ff) inside
         ST_START: begin
            if (req.opcode == cfg.put_const_code) next = ST_K;
            else if (req.opcode == cfg.load_local_code) next = ST_L;
         end
         ST_K: begin
            if (req.opcode == cfg.load_local_code) next = ST_KL;
            else if (req.opcode == cfg.put_const_code) next = ST_KK;
         end
         ST_L: begin
            if (req.opcode == cfg.load_local_code) next = ST_LL;
            else if (req.opcode == cfg.put_const_code) next = ST_KL;
         end
         ST_KL, ST_KK, ST_LL: begin
            arith_hit = 1'b1;
            if (req.opcode == cfg.mul_code) arith = 2'd0;
            else if (req.opcode == cfg.div_code) arith = 2'd1;
            else if (req.opcode == cfg.add_code) arith = 2'd2;
            else if (req.opcode == cfg.sub_code) arith = 2'd3;
            else arith_hit = 1'b0;
         end
         default: next = ST_START;
      endcase

      case (state_ff)
         ST_KK:   pair = PAIR_KK;
         ST_LL:   pair = PAIR_LL;
         default: pair = PAIR_KL;
      endcase
      lead_code  = (pair == PAIR_LL) ? cfg.load_local_code : cfg.put_const_code;
      trail_code = (pair == PAIR_KK) ? cfg.put_const_code : cfg.load_local_code;
      fused_op   = cfg.fused_base_code + {4'd0, pair, arith};

      win_in    = win_ff;
      fill_in   = fill_ff;
      state_in  = state_ff;
      push      = '0;

      if (accept) begin
         if (arith_hit && fill_ff == 2'd2) begin
            // fuse: one combined instruction now, window turns into nops
            push.item[0].out_opcode = fused_op;
            push.item[0].out_last   = 1'b0;
            if (win_ff[0].out_opcode == lead_code && win_ff[1].out_opcode == trail_code) begin
               push.item[0].out_flag = win_ff[0].out_wide;
               push.item[0].out_wide = win_ff[1].out_wide;
            end else begin
               push.item[0].out_flag = win_ff[1].out_wide;
               push.item[0].out_wide = win_ff[0].out_wide;
            end
            win_in[0] = nop_item;
            win_in[1] = nop_item;
            state_in  = ST_START;
            if (req.last) begin
               push.count   = 2'd3;
               push.item[1] = nop_item;
               push.item[2] = nop_item;
               push.item[2].out_last = 1'b1;
               fill_in      = 2'd0;
            end else begin
               push.count = 2'd1;
               fill_in    = 2'd2;
            end
         end else if (req.last) begin
            // flush the window, then the closing instruction
            state_in = ST_START;
            fill_in  = 2'd0;
            case (fill_ff)
               2'd0: begin
                  push.count   = 2'd1;
                  push.item[0] = cur;
               end
               2'd1: begin
                  push.count   = 2'd2;
                  push.item[0] = win_ff[0];
                  push.item[1] = cur;
               end
               default: begin
                  push.count   = 2'd3;
                  push.item[0] = win_ff[0];
                  push.item[1] = win_ff[1];
                  push.item[2] = cur;
               end
            endcase
         end else begin
            state_in = next;
            cur.out_last = 1'b0;
            case (fill_ff)
               2'd0: begin
                  win_in[0] = cur;
                  fill_in   = 2'd1;
               end
               2'd1: begin
                  win_in[1] = cur;
                  fill_in   = 2'd2;
               end
               default: begin
                  push.count   = 2'd1;
                  push.item[0] = win_ff[0];
                  win_in[0]    = win_ff[1];
                  win_in[1]    = cur;
                  fill_in      = 2'd2;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= 2'd0;
         state_ff <= ST_START;
      end else begin
         fill_ff  <= fill_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

// ===== sv/psf_out_queue.sv =====
// small result queue that takes up to three entries per cycle
module psf_out_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  psf_pkg::push_type        push,
   input  logic                     pop,
   output logic                     room,
   output logic                     valid,
   output psf_pkg::rsp_payload_type data,
   output logic [psf_pkg::QUEUE_AW:0] count
);

   localparam int AW = psf_pkg::QUEUE_AW;

   psf_pkg::rsp_payload_type mem_ff [psf_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;

   // room for the largest burst of one transaction
   assign room  = count_ff <= (AW+1)'(psf_pkg::QUEUE_DEPTH - psf_pkg::MAX_PUSH);
   assign valid = count_ff != '0;
   assign data  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + AW'(push.count);
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      count_in  = count_ff + (AW+1)'(push.count) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < psf_pkg::MAX_PUSH; k++) begin
         if (k < int'(push.count)) begin
            mem_ff[wr_ptr_ff + AW'(k)] <= push.item[k];
         end
      end
   end

endmodule
